[rtl/core/rpmr_pkg.sv]
// Shared types, widths and codes of the rectangle power map rasterizer.
package rpmr_pkg;

  // Field widths
  localparam int POS_W   = 24;
  localparam int PWR_W   = 32;
  localparam int AREA_W  = 28;
  localparam int IDX_W   = 12;
  localparam int COV_W   = 17;
  localparam int DENS_W  = 32;
  localparam int TOT_W   = 40;
  localparam int CFG_W   = 32;
  localparam int CFGI_W  = 3;
  localparam int GRID_W  = 7;
  localparam int REQ_W   = 2;

  // Internal arithmetic widths
  localparam int XW      = 34;          // cell edge coordinates
  localparam int PROD_W  = 48;          // overlap area and cell area products
  localparam int DVD_W   = 46;          // power shifted up by 14
  localparam int DVS_W   = 28;          // chiplet area
  localparam int GCMP_W  = 9;           // grid size compare width
  localparam int FRAC_SH = 14;          // Q14 shift of the density quotient

  // Constants
  localparam logic [COV_W-1:0]  ONE_Q16  = 17'd65536;
  localparam logic [COV_W-1:0]  BND_MAX  = 17'd65470;
  localparam logic [COV_W-1:0]  COV_CAP  = 17'h1FFFF;
  localparam logic [DVS_W-1:0]  AREA_ONE = 28'd16384;
  localparam logic [TOT_W-1:0]  SAT40    = 40'hFF_FFFF_FFFF;
  localparam logic [DENS_W-1:0] SAT32    = 32'hFFFF_FFFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_READ   = 2'd1,
    REQ_TOTALS = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [CFGI_W-1:0] {
    CFG_GRID_COLS = 3'd0,
    CFG_GRID_ROWS = 3'd1,
    CFG_CELL_W    = 3'd2,
    CFG_CELL_H    = 3'd3,
    CFG_INV_AREA  = 3'd4,
    CFG_SI_COND   = 3'd5
  } cfg_idx_e;

  // One grid cell in the store
  typedef struct packed {
    logic [COV_W-1:0]  cov;
    logic [DENS_W-1:0] dens;
    logic              bnd;
    logic              sil;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic add_start;
    logic rd_start;
    logic clr_start;
    logic clr_step;
    logic scan_issue;
    logic commit;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic div_done;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/rectangle_power_map_rasterizer_unit.sv]
// Top level of the rectangle power map rasterizer: controller plus datapath.
// Add chiplet: a 46-step divide for the density, then one store read-modify-write per cell
//   of the effective grid_rows*grid_cols grid.
// Read cell and read totals go straight to the response; clear sweeps all MAX_COLS*MAX_ROWS cells.
// One request is worked at a time; a finished result may wait while the next is taken.
// After reset all MAX_COLS*MAX_ROWS store cells are swept to zero before requests are taken.
module rectangle_power_map_rasterizer_unit import rpmr_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFGI_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [POS_W-1:0]        chiplet_x_i,
  input  logic [POS_W-1:0]        chiplet_y_i,
  input  logic [POS_W-1:0]        chiplet_width_i,
  input  logic [POS_W-1:0]        chiplet_height_i,
  input  logic [PWR_W-1:0]        chiplet_power_i,
  input  logic [AREA_W-1:0]       chiplet_area_i,
  input  logic [IDX_W-1:0]        cell_index_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [COV_W-1:0]        cell_coverage_o,
  output logic [DENS_W-1:0]       cell_density_o,
  output logic                    cell_boundary_o,
  output logic [DENS_W-1:0]       cell_silicon_o,
  output logic [TOT_W-1:0]        sum_power_before_o,
  output logic [TOT_W-1:0]        sum_power_after_o,
  output logic signed [TOT_W-1:0] power_delta_o,
  output logic                    mismatch_o
);

  cmd_t cmd;
  sts_t sts;

  rpmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpmr_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .chiplet_x_i        (chiplet_x_i),
    .chiplet_y_i        (chiplet_y_i),
    .chiplet_width_i    (chiplet_width_i),
    .chiplet_height_i   (chiplet_height_i),
    .chiplet_power_i    (chiplet_power_i),
    .chiplet_area_i     (chiplet_area_i),
    .cell_index_i       (cell_index_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .cell_coverage_o    (cell_coverage_o),
    .cell_density_o     (cell_density_o),
    .cell_boundary_o    (cell_boundary_o),
    .cell_silicon_o     (cell_silicon_o),
    .sum_power_before_o (sum_power_before_o),
    .sum_power_after_o  (sum_power_after_o),
    .power_delta_o      (power_delta_o),
    .mismatch_o         (mismatch_o)
  );

endmodule

[rtl/core/rpmr_divider.sv]
// Restoring divider, one quotient bit per cycle, for the chiplet density.
module rpmr_divider import rpmr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             ge;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/rpmr_datapath.sv]
// Datapath: configuration, cell store, cell pipeline, totals and result register.
module rpmr_datapath import rpmr_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFGI_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [POS_W-1:0]    chiplet_x_i,
  input  logic [POS_W-1:0]    chiplet_y_i,
  input  logic [POS_W-1:0]    chiplet_width_i,
  input  logic [POS_W-1:0]    chiplet_height_i,
  input  logic [PWR_W-1:0]    chiplet_power_i,
  input  logic [AREA_W-1:0]   chiplet_area_i,
  input  logic [IDX_W-1:0]    cell_index_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [COV_W-1:0]    cell_coverage_o,
  output logic [DENS_W-1:0]   cell_density_o,
  output logic                cell_boundary_o,
  output logic [DENS_W-1:0]   cell_silicon_o,
  output logic [TOT_W-1:0]    sum_power_before_o,
  output logic [TOT_W-1:0]    sum_power_after_o,
  output logic signed [TOT_W-1:0] power_delta_o,
  output logic                mismatch_o
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GXW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int GYW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [GRID_W-1:0] grid_cols_q, grid_rows_q;
  logic [POS_W-1:0]  cell_w_q, cell_h_q;
  logic [CFG_W-1:0]  inv_q, si_cond_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GRID_W'(64);
      grid_rows_q <= GRID_W'(64);
      cell_w_q    <= POS_W'(16384);
      cell_h_q    <= POS_W'(16384);
      inv_q       <= CFG_W'(32'h0100_0000);
      si_cond_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_COLS: grid_cols_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_ROWS: grid_rows_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_CELL_W:    cell_w_q    <= cfg_wdata_i[POS_W-1:0];
        CFG_CELL_H:    cell_h_q    <= cfg_wdata_i[POS_W-1:0];
        CFG_INV_AREA:  inv_q       <= cfg_wdata_i;
        CFG_SI_COND:   si_cond_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective grid and cell size
  logic [GCMP_W-1:0] cols_eff, rows_eff, gc_ext, gr_ext;
  logic [POS_W-1:0]  cw_eff, ch_eff;

  assign gc_ext = GCMP_W'(grid_cols_q);
  assign gr_ext = GCMP_W'(grid_rows_q);

  always_comb begin
    if (gc_ext == '0) cols_eff = GCMP_W'(1);
    else if (gc_ext > GCMP_W'(MAX_COLS)) cols_eff = GCMP_W'(MAX_COLS);
    else cols_eff = gc_ext;
    if (gr_ext == '0) rows_eff = GCMP_W'(1);
    else if (gr_ext > GCMP_W'(MAX_ROWS)) rows_eff = GCMP_W'(MAX_ROWS);
    else rows_eff = gr_ext;
  end

  assign cw_eff = (cell_w_q == '0) ? POS_W'(1) : cell_w_q;
  assign ch_eff = (cell_h_q == '0) ? POS_W'(1) : cell_h_q;

  // ---------------------------------------------------------------
  // Density divider
  logic [DVD_W-1:0] quotient;
  logic [DVS_W-1:0] area_eff;
  logic             div_done;
  logic [DENS_W-1:0] dens_q;

  assign area_eff = (chiplet_area_i == '0) ? AREA_ONE : chiplet_area_i;

  rpmr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.add_start),
    .dividend_i ({chiplet_power_i, FRAC_SH'(0)}),
    .divisor_i  (area_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Capture the rectangle and per-request constants
  logic [POS_W-1:0]  x0_q, y0_q;
  logic [POS_W:0]    x1_q, y1_q;
  logic [PROD_W-1:0] cwch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_start) begin
      x0_q   <= chiplet_x_i;
      y0_q   <= chiplet_y_i;
      x1_q   <= {1'b0, chiplet_x_i} + {1'b0, chiplet_width_i};
      y1_q   <= {1'b0, chiplet_y_i} + {1'b0, chiplet_height_i};
      cwch_q <= PROD_W'(cw_eff) * PROD_W'(ch_eff);
    end
    if (div_done) begin
      dens_q <= (|quotient[DVD_W-1:DENS_W]) ? SAT32 : quotient[DENS_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Cell walk counters, shared with the clearing sweep
  logic [AW-1:0]  idx_q;
  logic [GXW-1:0] gx_q;
  logic [GYW-1:0] gy_q;
  logic [XW-1:0]  cx0_q, cy0_q;
  logic           col_last, row_last;

  assign col_last = GCMP_W'(gx_q) == (cols_eff - GCMP_W'(1));
  assign row_last = GCMP_W'(gy_q) == (rows_eff - GCMP_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      gx_q  <= '0;
      gy_q  <= '0;
      cx0_q <= '0;
      cy0_q <= '0;
    end else if (cmd_i.add_start || cmd_i.clr_start) begin
      idx_q <= '0;
      gx_q  <= '0;
      gy_q  <= '0;
      cx0_q <= '0;
      cy0_q <= '0;
    end else if (cmd_i.clr_step) begin
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.scan_issue) begin
      idx_q <= idx_q + 1'b1;
      if (col_last) begin
        gx_q  <= '0;
        cx0_q <= '0;
        gy_q  <= gy_q + 1'b1;
        cy0_q <= cy0_q + XW'(ch_eff);
      end else begin
        gx_q  <= gx_q + 1'b1;
        cx0_q <= cx0_q + XW'(cw_eff);
      end
    end
  end

  // ---------------------------------------------------------------
  // Overlap of the rectangle with the issued cell
  logic [XW-1:0] cx1, cy1, xa, xb, ya, yb, ix0, ix1, iy0, iy1, dx, dy;
  logic          ovl;

  assign cx1 = cx0_q + XW'(cw_eff);
  assign cy1 = cy0_q + XW'(ch_eff);
  assign xa  = XW'(x0_q);
  assign xb  = XW'(x1_q);
  assign ya  = XW'(y0_q);
  assign yb  = XW'(y1_q);
  assign ix0 = (cx0_q > xa) ? cx0_q : xa;
  assign ix1 = (cx1 < xb) ? cx1 : xb;
  assign iy0 = (cy0_q > ya) ? cy0_q : ya;
  assign iy1 = (cy1 < yb) ? cy1 : yb;
  assign dx  = ix1 - ix0;
  assign dy  = iy1 - iy0;
  assign ovl = (ix1 > ix0) && (iy1 > iy0);

  // ---------------------------------------------------------------
  // Cell store
  entry_t        mem_q [DEPTH];
  entry_t        rdata_q;
  entry_t        mem_wd, new_ent;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;

  // Pipeline registers
  logic [10:1]        v_q;
  logic [POS_W-1:0]   p1_ix, p1_iy;
  logic [PROD_W-1:0]  p2_prod;
  logic [63:0]        p3_lo;
  logic [15:0]        p3_phi;
  logic [47:0]        p4_hi;
  logic [31:0]        p4_lomsb;
  logic [COV_W-1:0]   p5_cov, p6_cov;
  logic [32:0]        p6_dt;
  logic [DENS_W-1:0]  p7_dens, p8_dens;
  logic [63:0]        p8_tlo;
  logic [47:0]        p9_thi;
  logic [35:0]        p9_losh;
  logic [TOT_W-1:0]   p10_t;
  logic               p1_ovl, p2_ovl, p3_ovl, p4_ovl, p5_ovl, p6_ovl;
  logic [AW-1:0]      p1_addr, p2_addr, p3_addr, p4_addr, p5_addr, p6_addr;
  entry_t             p2_ent, p3_ent, p4_ent, p5_ent, p6_ent;

  assign mem_we = cmd_i.clr_step | v_q[6];
  assign mem_wa = cmd_i.clr_step ? idx_q : p6_addr;
  assign mem_wd = cmd_i.clr_step ? entry_t'('0) : new_ent;
  assign mem_re = cmd_i.rd_start | cmd_i.scan_issue;
  assign mem_ra = cmd_i.rd_start ? AW'(cell_index_i) : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem_q[mem_ra];
  end

  // Advance the valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= {v_q[9:1], cmd_i.scan_issue};
  end

  // Combinational pieces of the stages
  logic [48:0]      cov_sum49, dprod;
  logic [44:0]      cov_raw;
  logic [COV_W:0]   cov_acc;
  logic [33:0]      dens_acc;
  logic [52:0]      t53;
  logic [TOT_W:0]   sum_acc;

  assign cov_sum49 = 49'(p4_hi) + 49'(p4_lomsb);
  assign cov_raw   = cov_sum49[48:4];
  assign dprod     = 49'(dens_q) * 49'(p5_cov);
  assign cov_acc   = {1'b0, p6_ent.cov} + {1'b0, p6_cov};
  assign dens_acc  = 34'(p6_ent.dens) + 34'(p6_dt);
  assign t53       = {1'b0, p9_thi, 4'b0} + 53'(p9_losh);

  // Merge the contribution into the stored cell
  always_comb begin
    new_ent = p6_ent;
    if (p6_ovl) begin
      new_ent.cov  = (cov_acc > {1'b0, ONE_Q16}) ? ONE_Q16 : cov_acc[COV_W-1:0];
      new_ent.dens = (|dens_acc[33:32]) ? SAT32 : dens_acc[DENS_W-1:0];
      new_ent.sil  = 1'b1;
      new_ent.bnd  = p6_ent.bnd | (p6_cov <= BND_MAX);
    end
  end

  // Stage registers
  always_ff @(posedge clk_i) begin
    p1_ix    <= ovl ? dx[POS_W-1:0] : '0;
    p1_iy    <= ovl ? dy[POS_W-1:0] : '0;
    p1_ovl   <= ovl;
    p1_addr  <= idx_q;

    p2_prod  <= PROD_W'(p1_ix) * PROD_W'(p1_iy);
    p2_ovl   <= p1_ovl;
    p2_addr  <= p1_addr;
    p2_ent   <= rdata_q;

    p3_lo    <= 64'(p2_prod[31:0]) * 64'(inv_q);
    p3_phi   <= p2_prod[47:32];
    p3_ovl   <= p2_ovl;
    p3_addr  <= p2_addr;
    p3_ent   <= p2_ent;

    p4_hi    <= 48'(p3_phi) * 48'(inv_q);
    p4_lomsb <= p3_lo[63:32];
    p4_ovl   <= p3_ovl;
    p4_addr  <= p3_addr;
    p4_ent   <= p3_ent;

    p5_cov   <= (|cov_raw[44:COV_W]) ? COV_CAP : cov_raw[COV_W-1:0];
    p5_ovl   <= p4_ovl;
    p5_addr  <= p4_addr;
    p5_ent   <= p4_ent;

    p6_dt    <= dprod[48:16];
    p6_cov   <= p5_cov;
    p6_ovl   <= p5_ovl;
    p6_addr  <= p5_addr;
    p6_ent   <= p5_ent;

    p7_dens  <= new_ent.dens;

    p8_tlo   <= 64'(cwch_q[31:0]) * 64'(p7_dens);
    p8_dens  <= p7_dens;

    p9_thi   <= 48'(cwch_q[47:32]) * 48'(p8_dens);
    p9_losh  <= p8_tlo[63:28];

    p10_t    <= (|t53[52:TOT_W]) ? SAT40 : t53[TOT_W-1:0];
  end

  // ---------------------------------------------------------------
  // Totals
  logic [TOT_W-1:0] before_q, after_q, sum_q;
  logic [TOT_W:0]   before_acc;

  assign before_acc = {1'b0, before_q} + (TOT_W+1)'(chiplet_power_i);
  assign sum_acc    = {1'b0, sum_q} + {1'b0, p10_t};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= '0;
      after_q  <= '0;
      sum_q    <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        before_q <= '0;
        after_q  <= '0;
      end
      if (cmd_i.add_start) begin
        before_q <= before_acc[TOT_W] ? SAT40 : before_acc[TOT_W-1:0];
        sum_q    <= '0;
      end else if (v_q[10]) begin
        sum_q <= sum_acc[TOT_W] ? SAT40 : sum_acc[TOT_W-1:0];
      end
      if (cmd_i.commit) after_q <= sum_q;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  logic                   rsp_cell_q;
  logic                   out_valid_q;
  logic signed [TOT_W:0]  err;
  logic [TOT_W:0]         mag;
  logic [47:0]            mag100;
  logic [TOT_W-1:0]       err_sat;

  assign err    = $signed({1'b0, after_q}) - $signed({1'b0, before_q});
  assign mag    = err[TOT_W] ? unsigned'(-err) : unsigned'(err);
  assign mag100 = 48'(mag) * 48'd100;

  always_comb begin
    if (err[TOT_W] != err[TOT_W-1]) begin
      err_sat = err[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    end else begin
      err_sat = err[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_cell_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) rsp_cell_q <= cmd_i.rd_start && (int'(cell_index_i) < DEPTH);
      if (cmd_i.load_out)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cell_coverage_o    <= rsp_cell_q ? rdata_q.cov : '0;
      cell_density_o     <= rsp_cell_q ? rdata_q.dens : '0;
      cell_boundary_o    <= rsp_cell_q & rdata_q.bnd;
      cell_silicon_o     <= (rsp_cell_q && rdata_q.sil) ? si_cond_q : '0;
      sum_power_before_o <= before_q;
      sum_power_after_o  <= after_q;
      power_delta_o      <= signed'(err_sat);
      mismatch_o         <= (mag >= (TOT_W+1)'(66)) && (mag100 > 48'(before_q));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.clr_last  = idx_q == AW'(DEPTH - 1);
  assign sts_o.scan_last = col_last && row_last;
  assign sts_o.div_done  = div_done;
  assign sts_o.pipe_busy = |v_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------
  // Assertions
  a_no_clear_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_step && v_q[6]))
    else $error("clearing sweep collides with a cell write");

  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[10] |=> sum_q >= $past(sum_q))
    else $error("power sum decreased during a walk");

  a_single_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.scan_issue && cmd_i.rd_start))
    else $error("two store reads requested at once");

endmodule

[rtl/core/rpmr_ctrl.sv]
// Controller state machine: sequences clearing, density divide, cell walk and response.
module rpmr_ctrl import rpmr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             in_ready_o,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_READ  = 9'b001000000,
    S_RESP  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      // Sweep the store after reset
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      // Take a request and dispatch on its type
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          unique case (req_e'(req_type_i))
            REQ_ADD: begin
              cmd_o.add_start = 1'b1;
              state_d = S_DIV;
            end
            REQ_READ: begin
              cmd_o.rd_start = 1'b1;
              state_d = S_READ;
            end
            REQ_TOTALS: state_d = S_RESP;
            REQ_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d = S_CLEAR;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_RESP;
      end
      // Wait for the density quotient
      S_DIV: begin
        if (sts_i.div_done) state_d = S_SCAN;
      end
      // Issue one cell per cycle
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.commit = 1'b1;
          state_d = S_RESP;
        end
      end
      S_READ: state_d = S_RESP;
      // Load the result once the output register is free
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else         state_q <= state_d;
  end

  // Assertions
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.pipe_busy)
    else $error("cell pipeline busy while idle");

  a_div_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  a_resp_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> !sts_i.pipe_busy)
    else $error("response issued before the walk drained");

endmodule
